/* hw/rtl/bscm_pkg.sv */
// ----------------------------------------------------------------------------
// Banked SRAM cartridge mapper package
// Shared constants, codes and types for the mapper and its decoder.
// ----------------------------------------------------------------------------
package bscm_pkg;

   // SRAM geometry.
   localparam int MAX_SEGMENTS  = 64;
   localparam int SEGMENT_BYTES = 8192;
   localparam int SRAM_BYTES    = MAX_SEGMENTS * SEGMENT_BYTES;
   localparam int SRAM_AW       = $clog2(SRAM_BYTES);
   localparam int OFFSET_W      = $clog2(SEGMENT_BYTES);

   // Field widths.
   localparam int ADDR_W    = 16;
   localparam int DATA_W    = 8;
   localparam int SEG_W     = 7;
   localparam int PAGE_W    = ADDR_W - OFFSET_W;
   localparam int NUM_BANKS = 4;
   localparam int BANK_IW   = $clog2(NUM_BANKS);

   // Segment limit compared with one extra bit so that 128 fits.
   localparam logic [SEG_W:0] SEG_LIMIT = (SEG_W + 1)'(MAX_SEGMENTS);

   // Pages that go through the bank registers, and the bank-select page.
   localparam logic [PAGE_W-1:0] PAGE_BANK_LO  = PAGE_W'(2);
   localparam logic [PAGE_W-1:0] PAGE_BANK_HI  = PAGE_W'(5);
   localparam logic [PAGE_W-1:0] PAGE_BANK_SEL = PAGE_W'(3);

   // Bit of a bank register that enables SRAM writes.
   localparam int BANK_WE_BIT = 7;

   // Reset value of the segment count and the byte returned when unmapped.
   localparam logic [SEG_W-1:0]  SEG_COUNT_RESET = SEG_W'(64);
   localparam logic [DATA_W-1:0] UNMAPPED_BYTE   = 8'hFF;

   // Access kinds.
   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   // What the decoder asks of the SRAM and reports for one beat.
   typedef struct packed {
      logic               rd_en;
      logic               wr_en;
      logic               hit;
      logic               accepted;
      logic [SRAM_AW-1:0] addr;
   } mem_access_type;

endpackage

/* hw/rtl/bscm_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle; read data is registered and holds until the
// next read.
// ----------------------------------------------------------------------------
module bscm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/bscm_decode.sv */
// ----------------------------------------------------------------------------
// Mapper address decoder
// Holds the four bank registers, loads them on bank-select writes and turns
// each CPU access into an SRAM read, an SRAM write or nothing.
// ----------------------------------------------------------------------------
module bscm_decode
   import bscm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 beat_accept,
   input  logic                 op,
   input  logic [ADDR_W-1:0]    address,
   input  logic [DATA_W-1:0]    write_data,
   input  logic [SEG_W-1:0]     segment_count,
   output mem_access_type       access
);

   logic [DATA_W-1:0]   bank_ff [NUM_BANKS];
   logic [DATA_W-1:0]   bank_in [NUM_BANKS];
   logic [PAGE_W-1:0]   page;
   logic [OFFSET_W-1:0] offset;
   logic [PAGE_W-1:0]   page_rel;
   logic [BANK_IW-1:0]  bank_idx;
   logic [DATA_W-1:0]   bank;
   logic [SEG_W-1:0]    seg;
   logic                mapped;
   logic                in_range;
   logic                is_write;
   logic                bank_sel_wr;
   logic                store;

   // Split the address into page and offset and look up the page's bank.
   assign page     = address[ADDR_W-1:OFFSET_W];
   assign offset   = address[OFFSET_W-1:0];
   assign page_rel = page - PAGE_BANK_LO;
   assign bank_idx = page_rel[BANK_IW-1:0];
   assign bank     = bank_ff[bank_idx];
   assign seg      = bank[SEG_W-1:0];

   // A segment is usable when it lies below both the count and the SRAM size.
   assign mapped   = (page >= PAGE_BANK_LO) && (page <= PAGE_BANK_HI);
   assign in_range = mapped && ({1'b0, seg} < {1'b0, segment_count})
                     && ({1'b0, seg} < SEG_LIMIT);

   // Writes either load a bank register or store into an enabled segment.
   assign is_write    = (op == OP_WRITE);
   assign bank_sel_wr = is_write && (page == PAGE_BANK_SEL);
   assign store       = is_write && !bank_sel_wr && bank[BANK_WE_BIT] && in_range;

   // Request to the SRAM and status for the response.
   always_comb begin
      access.rd_en    = beat_accept && !is_write && in_range;
      access.wr_en    = beat_accept && store;
      access.hit      = !is_write && in_range;
      access.accepted = is_write ? (bank_sel_wr || store) : in_range;
      access.addr     = SRAM_AW'({seg, offset});
   end

   // Next value of the bank registers.
   always_comb begin
      for (int i = 0; i < NUM_BANKS; i++) begin
         bank_in[i] = bank_ff[i];
      end
      if (beat_accept && bank_sel_wr) begin
         bank_in[address[OFFSET_W-1:OFFSET_W-BANK_IW]] = write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BANKS; i++) begin
            bank_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < NUM_BANKS; i++) begin
            bank_ff[i] <= bank_in[i];
         end
      end
   end

endmodule

/* hw/rtl/banked_sram_cartridge_mapper.sv */
// ----------------------------------------------------------------------------
// Banked SRAM cartridge mapper
// Eight 8 KB pages; pages 2 to 5 map through four bank registers into a
// segmented SRAM, with bank-select writes at 0x6000-0x7FFF.
// ----------------------------------------------------------------------------
// Path: a taken request beat passes the SRAM stage register and then the output register before its response is valid.
// Throughput: one beat per cycle while rsp_ready holds, set by the single SRAM port that serves
// one read or one write per cycle; a stalled response holds back new beats.
// Reset: bank registers clear to zero, segment_count returns to 64 and the
// pipeline empties; SRAM contents are kept, with no clearing pass.
module banked_sram_cartridge_mapper
   import bscm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_op,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [DATA_W-1:0] req_write_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DATA_W-1:0] rsp_read_data,
   output logic              rsp_accepted,
   input  logic              csr_write_enable,
   input  logic [SEG_W-1:0]  csr_write_data
);

   logic [SEG_W-1:0]  segment_count_ff;
   logic [SEG_W-1:0]  segment_count_in;
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic              s1_hit_ff;
   logic              s1_acc_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [DATA_W-1:0] rsp_read_data_ff;
   logic              rsp_accepted_ff;
   logic              beat_accept;
   logic              s1_advance;
   logic [DATA_W-1:0] ram_rd_data;
   mem_access_type    access;

   // The SRAM stage moves on when the output register is empty or drained.
   assign s1_advance  = !rsp_valid_ff || rsp_ready;
   assign req_ready   = !s1_valid_ff || s1_advance;
   assign beat_accept = req_valid && req_ready;

   // Segment count register.
   assign segment_count_in = csr_write_enable ? csr_write_data : segment_count_ff;

   // Address decode and bank registers.
   bscm_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .beat_accept   (beat_accept),
      .op            (req_op),
      .address       (req_address),
      .write_data    (req_write_data),
      .segment_count (segment_count_ff),
      .access        (access)
   );

   // Segmented SRAM; read data holds while the SRAM stage is stalled.
   bscm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (SRAM_BYTES)
   ) u_sram (
      .clock   (clock),
      .wr_en   (access.wr_en),
      .rd_en   (access.rd_en),
      .addr    (access.addr),
      .wr_data (req_write_data),
      .rd_data (ram_rd_data)
   );

   // Pipeline valid bits.
   always_comb begin
      s1_valid_in  = beat_accept ? 1'b1 : (s1_valid_ff && !s1_advance);
      rsp_valid_in = (s1_valid_ff && s1_advance) ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         segment_count_ff <= SEG_COUNT_RESET;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         segment_count_ff <= segment_count_in;
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // SRAM stage status and output payload.
   always_ff @(posedge clock) begin
      if (beat_accept) begin
         s1_hit_ff <= access.hit;
         s1_acc_ff <= access.accepted;
      end
      if (s1_valid_ff && s1_advance) begin
         rsp_read_data_ff <= s1_hit_ff ? ram_rd_data : UNMAPPED_BYTE;
         rsp_accepted_ff  <= s1_acc_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_accepted  = rsp_accepted_ff;

endmodule

/* hw/rtl/bscm_checker.sv */
// ----------------------------------------------------------------------------
// Mapper port checker
// Watches the mapper's ports for response ordering, stall behavior and the
// byte returned on beats that were not accepted.
// ----------------------------------------------------------------------------
module bscm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_read_data,
   input logic        rsp_accepted
);

   logic [2:0] pending_ff;
   logic [2:0] pending_in;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // Beats taken in but not yet answered.
   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) begin
         pending_in = pending_ff + 3'd1;
      end else if (rsp_beat && !req_beat) begin
         pending_in = pending_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
                                  && $stable(rsp_accepted))
      else $error("response changed while stalled");

   // A beat that was not accepted returns the unmapped byte.
   a_miss_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> rsp_read_data == 8'hFF)
      else $error("unaccepted beat returned data other than 0xFF");

   // Reset empties the output.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // No more than two beats are ever in flight.
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd2)
      else $error("more than two beats in flight");

   // Every response answers a request that was taken.
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("response without a pending request");

endmodule

bind banked_sram_cartridge_mapper bscm_checker u_bscm_checker (.*);
